// ===== hdl/fik_pkg.sv =====
package fik_pkg;

    localparam int MAX_JOINTS = 16;
    localparam int JIDX_W     = 4;
    localparam int COORD_W    = 32;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int R_W        = 31;
    localparam int MAG_W      = 33;
    localparam int LEN_W      = 32;
    localparam int SUM_W      = 2 * MAG_W;
    localparam int NUM_W      = 63;
    localparam int QUO_W      = 33;
    localparam int ROOT_W     = 32;
    localparam int RAD_W      = 64;
    localparam int SEG_DEPTH  = MAX_JOINTS - 1;

    localparam logic [1:0] REG_JOINT_COUNT     = 2'd0;
    localparam logic [1:0] REG_MAX_ITERATIONS  = 2'd1;
    localparam logic [1:0] REG_ERROR_THRESHOLD = 2'd2;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } vec_t;

    typedef struct packed {
        logic              we;
        logic [JIDX_W-1:0] addr;
        vec_t              data;
    } mem_wr_t;

    function automatic logic [MAG_W-1:0] abs_diff(input logic signed [DIFF_W-1:0] v);
        logic [DIFF_W-1:0] n;
        begin
            n = v[DIFF_W-1] ? (~v + 1'b1) : v;
            abs_diff = n;
        end
    endfunction

    function automatic coord_t sat_coord(input logic signed [COORD_W+2:0] v);
        logic signed [COORD_W+2:0] hi;
        logic signed [COORD_W+2:0] lo;
        begin
            hi = {{3{1'b0}}, 1'b0, {(COORD_W-1){1'b1}}};
            lo = {{3{1'b1}}, 1'b1, {(COORD_W-1){1'b0}}};
            if (v > hi)
                sat_coord = hi[COORD_W-1:0];
            else if (v < lo)
                sat_coord = lo[COORD_W-1:0];
            else
                sat_coord = v[COORD_W-1:0];
        end
    endfunction

endpackage

// ===== hdl/fik_joint_mem.sv =====
module fik_joint_mem
    import fik_pkg::*;
(
    input  logic              clk,
    input  mem_wr_t           wr,
    input  logic [JIDX_W-1:0] raddr,
    output vec_t              rdata
);

    vec_t mem [0:MAX_JOINTS-1];
    vec_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/fik_isqrt.sv =====
module fik_isqrt
    import fik_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [RAD_W-1:0]  radicand,
    output logic              done,
    output logic [ROOT_W-1:0] root
);

    logic [RAD_W-1:0] n_reg,   n_next;
    logic [RAD_W-1:0] res_reg, res_next;
    logic [RAD_W-1:0] bit_reg, bit_next;
    logic [5:0]       cnt_reg, cnt_next;
    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [RAD_W-1:0] trial;

    always_comb
    begin
        n_next    = n_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        trial     = res_reg + bit_reg;
        if (start)
        begin
            n_next   = radicand;
            res_next = '0;
            bit_next = {2'b01, {(RAD_W-2){1'b0}}};
            cnt_next = 6'd32;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (n_reg >= trial)
            begin
                n_next   = n_reg - trial;
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign done = done_reg;
    assign root = res_reg[ROOT_W-1:0];

endmodule

// ===== hdl/fik_div.sv =====
module fik_div
    import fik_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] dividend,
    input  logic [R_W-1:0]   divisor,
    output logic             done,
    output logic [QUO_W-1:0] quotient
);

    // The quotient never exceeds 33 bits, so the upper dividend bits seed the
    // remainder directly and only the low 33 bits are shifted through.
    logic [R_W-1:0]   rem_reg, rem_next;
    logic [QUO_W-1:0] q_reg,   q_next;
    logic [5:0]       cnt_reg, cnt_next;
    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [R_W:0]     trial;
    logic             qbit;

    always_comb
    begin
        rem_next  = rem_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        trial     = {rem_reg, q_reg[QUO_W-1]};
        qbit      = (trial >= {1'b0, divisor});
        if (start)
        begin
            rem_next = {1'b0, dividend[NUM_W-1:QUO_W]};
            q_next   = dividend[QUO_W-1:0];
            cnt_next = 6'(QUO_W);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (qbit)
                rem_next = R_W'(trial - {1'b0, divisor});
            else
                rem_next = trial[R_W-1:0];
            q_next   = {q_reg[QUO_W-2:0], qbit};
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// ===== hdl/fabrik_ik_solver.sv =====
// FABRIK inverse kinematics in signed Q16.16. A load transaction writes one
// joint; a solve transaction measures all segments, runs up to
// max_iterations forward/backward sweeps and then emits one result
// transaction per joint of the clamped joint count, index 0 first, with last
// set on the final joint. The block takes one transaction at a time. After
// reset a pass clears the joint memory to zero, with in_stall held high.
// Joints live in a memory with one write port and a registered read. Every
// segment step goes through a shared iterative square root, and every sweep
// step whose two joints do not coincide goes through three parallel
// bit-serial dividers.
module fabrik_ik_solver
    import fik_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              action,
    input  logic [JIDX_W-1:0] joint_index,
    input  coord_t            coord_x,
    input  coord_t            coord_y,
    input  coord_t            coord_z,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [JIDX_W-1:0] out_index,
    output coord_t            out_x,
    output coord_t            out_y,
    output coord_t            out_z,
    output logic              last,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [31:0]       cfg_data
);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_RA     = 5'd1;
    localparam logic [4:0] S_RB     = 5'd2;
    localparam logic [4:0] S_RC     = 5'd3;
    localparam logic [4:0] S_DIFF   = 5'd4;
    localparam logic [4:0] S_SHIFT  = 5'd5;
    localparam logic [4:0] S_SQ     = 5'd6;
    localparam logic [4:0] S_SQRT   = 5'd7;
    localparam logic [4:0] S_SQRTW  = 5'd8;
    localparam logic [4:0] S_SEGWR  = 5'd9;
    localparam logic [4:0] S_MUL    = 5'd10;
    localparam logic [4:0] S_DIVGO  = 5'd11;
    localparam logic [4:0] S_DIVW   = 5'd12;
    localparam logic [4:0] S_APPLY  = 5'd13;
    localparam logic [4:0] S_ITCHK  = 5'd14;
    localparam logic [4:0] S_CHKRD  = 5'd15;
    localparam logic [4:0] S_CHKD   = 5'd16;
    localparam logic [4:0] S_SETEND = 5'd17;
    localparam logic [4:0] S_SETORG = 5'd18;
    localparam logic [4:0] S_OUTRD  = 5'd19;
    localparam logic [4:0] S_OUTLD  = 5'd20;
    localparam logic [4:0] S_OUTW   = 5'd21;
    localparam logic [4:0] S_CLR    = 5'd22;

    localparam logic [1:0] PH_MEAS = 2'd0;
    localparam logic [1:0] PH_FWD  = 2'd1;
    localparam logic [1:0] PH_BWD  = 2'd2;

    // Configuration.
    logic [4:0]  jcount_reg;
    logic [7:0]  max_iter_reg;
    logic [31:0] thr_reg;

    // Control.
    logic [4:0]        state_reg, state_next;
    logic [1:0]        phase_reg, phase_next;
    logic [JIDX_W-1:0] i_reg, i_next;
    logic [JIDX_W-1:0] lastj_reg, lastj_next;
    logic [7:0]        iter_reg, iter_next;
    logic [2:0]        k_reg, k_next;
    logic              chk_reg, chk_next;
    logic              outv_reg, outv_next;

    // Datapath.
    vec_t                     pa_reg, pb_reg, tgt_reg, org_reg;
    logic signed [DIFF_W-1:0] d_reg [0:2];
    logic [R_W-1:0]           rmag_reg [0:2];
    logic                     rneg_reg [0:2];
    logic [1:0]               s_reg;
    logic [MAG_W-1:0]         a_reg [0:2];
    logic [SUM_W-1:0]         prod_reg, sum_reg;
    logic [ROOT_W-1:0]        m_reg;
    logic [LEN_W-1:0]         len_reg;
    logic [NUM_W-1:0]         num_reg [0:2];
    logic [JIDX_W-1:0]        oidx_reg;
    vec_t                     opos_reg;
    logic                     olast_reg;

    logic [LEN_W-1:0] seg_mem [0:SEG_DEPTH-1];
    logic [LEN_W-1:0] seg_rd_reg;
    logic             seg_we;
    logic [LEN_W-1:0] seg_wdata;

    mem_wr_t           jwr;
    logic [JIDX_W-1:0] jraddr;
    vec_t              jrdata;

    logic              sq_start, sq_done;
    logic [ROOT_W-1:0] sq_root;
    logic              dv_start;
    logic [2:0]        dv_done;
    logic [QUO_W-1:0]  dv_q [0:2];

    logic [4:0]        n_clamp;
    logic [MAG_W-1:0]  mul_op;
    logic [MAG_W-1:0]  mx;
    logic [1:0]        s_calc;
    logic [COORD_W+2:0] ext_len;
    coord_t            src_c [0:2];
    coord_t            new_c [0:2];
    coord_t            tgt_c [0:2];
    coord_t            rd_c  [0:2];
    coord_t            pa_c  [0:2];
    coord_t            pb_c  [0:2];

    fik_joint_mem u_mem (
        .clk   (clk),
        .wr    (jwr),
        .raddr (jraddr),
        .rdata (jrdata)
    );

    fik_isqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (sum_reg[RAD_W-1:0]),
        .done     (sq_done),
        .root     (sq_root)
    );

    genvar g;
    generate
        for (g = 0; g < 3; g++)
        begin : g_div
            fik_div u_div (
                .clk      (clk),
                .rst_n    (rst_n),
                .start    (dv_start),
                .dividend (num_reg[g]),
                .divisor  (m_reg[R_W-1:0]),
                .done     (dv_done[g]),
                .quotient (dv_q[g])
            );
        end
    endgenerate

    assign pa_c[0]  = pa_reg.x;
    assign pa_c[1]  = pa_reg.y;
    assign pa_c[2]  = pa_reg.z;
    assign pb_c[0]  = pb_reg.x;
    assign pb_c[1]  = pb_reg.y;
    assign pb_c[2]  = pb_reg.z;
    assign tgt_c[0] = tgt_reg.x;
    assign tgt_c[1] = tgt_reg.y;
    assign tgt_c[2] = tgt_reg.z;
    assign rd_c[0]  = jrdata.x;
    assign rd_c[1]  = jrdata.y;
    assign rd_c[2]  = jrdata.z;

    always_comb
    begin
        if (jcount_reg < 5'd2)
            n_clamp = 5'd2;
        else if (jcount_reg > 5'(MAX_JOINTS))
            n_clamp = 5'(MAX_JOINTS);
        else
            n_clamp = jcount_reg;
    end

    // Shift that brings every difference below 2^30 in magnitude.
    always_comb
    begin
        mx = abs_diff(d_reg[0]);
        if (abs_diff(d_reg[1]) > mx)
            mx = abs_diff(d_reg[1]);
        if (abs_diff(d_reg[2]) > mx)
            mx = abs_diff(d_reg[2]);
        if (mx[MAG_W-1:30] == '0)
            s_calc = 2'd0;
        else if (mx[MAG_W-1:31] == '0)
            s_calc = 2'd1;
        else if (mx[MAG_W-1:32] == '0)
            s_calc = 2'd2;
        else
            s_calc = 2'd3;
    end

    always_comb
    begin
        case (k_reg)
            3'd0:    mul_op = chk_reg ? a_reg[0] : MAG_W'(rmag_reg[0]);
            3'd1:    mul_op = chk_reg ? a_reg[1] : MAG_W'(rmag_reg[1]);
            3'd2:    mul_op = chk_reg ? a_reg[2] : MAG_W'(rmag_reg[2]);
            3'd3:    mul_op = MAG_W'(thr_reg);
            default: mul_op = '0;
        endcase
    end

    assign ext_len = (COORD_W+3)'(m_reg) << s_reg;

    // New joint position: step from the source joint along the direction.
    always_comb
    begin
        logic signed [COORD_W+2:0] off;
        logic signed [COORD_W+2:0] sum;
        for (int c = 0; c < 3; c++)
        begin
            src_c[c] = (phase_reg == PH_FWD) ? pb_c[c] : pa_c[c];
            off      = (m_reg == '0) ? '0 : (COORD_W+3)'(dv_q[c]);
            if (rneg_reg[c])
                off = -off;
            if (phase_reg == PH_FWD)
                sum = (COORD_W+3)'(src_c[c]) - off;
            else
                sum = (COORD_W+3)'(src_c[c]) + off;
            new_c[c] = sat_coord(sum);
        end
    end

    always_comb
    begin
        jraddr = i_reg;
        case (state_reg)
            S_RB:    jraddr = i_reg + 1'b1;
            S_CHKRD: jraddr = lastj_reg;
            default: jraddr = i_reg;
        endcase
    end

    always_comb
    begin
        jwr.we   = 1'b0;
        jwr.addr = i_reg;
        jwr.data = tgt_reg;
        case (state_reg)
            S_CLR:
            begin
                jwr.we   = 1'b1;
                jwr.addr = i_reg;
                jwr.data = '0;
            end
            S_IDLE:
            begin
                jwr.we   = in_valid && !action;
                jwr.addr = joint_index;
                jwr.data = '{x: coord_x, y: coord_y, z: coord_z};
            end
            S_SETEND:
            begin
                jwr.we   = 1'b1;
                jwr.addr = lastj_reg;
                jwr.data = tgt_reg;
            end
            S_SETORG:
            begin
                jwr.we   = 1'b1;
                jwr.addr = '0;
                jwr.data = org_reg;
            end
            S_APPLY:
            begin
                jwr.we   = 1'b1;
                jwr.addr = (phase_reg == PH_FWD) ? i_reg : i_reg + 1'b1;
                jwr.data = '{x: new_c[0], y: new_c[1], z: new_c[2]};
            end
            default:
            begin
                jwr.we = 1'b0;
            end
        endcase
    end

    assign seg_we    = (state_reg == S_SEGWR);
    assign seg_wdata = (ext_len[COORD_W+2:LEN_W] != '0) ? {LEN_W{1'b1}}
                                                       : ext_len[LEN_W-1:0];
    assign sq_start  = (state_reg == S_SQRT);
    assign dv_start  = (state_reg == S_DIVGO);

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        i_next     = i_reg;
        lastj_next = lastj_reg;
        iter_next  = iter_reg;
        k_next     = k_reg;
        chk_next   = chk_reg;
        outv_next  = outv_reg;
        case (state_reg)
            S_CLR:
            begin
                if (i_reg == JIDX_W'(MAX_JOINTS - 1))
                begin
                    i_next     = '0;
                    state_next = S_IDLE;
                end
                else
                    i_next = i_reg + 1'b1;
            end
            S_IDLE:
            begin
                if (in_valid && action)
                begin
                    lastj_next = JIDX_W'(n_clamp - 5'd1);
                    phase_next = PH_MEAS;
                    i_next     = '0;
                    state_next = S_RA;
                end
            end
            S_RA:    state_next = S_RB;
            S_RB:    state_next = S_RC;
            S_RC:    state_next = S_DIFF;
            S_DIFF:  state_next = S_SHIFT;
            S_SHIFT:
            begin
                k_next     = '0;
                chk_next   = 1'b0;
                state_next = S_SQ;
            end
            S_SQ:
            begin
                k_next = k_reg + 3'd1;
                if (!chk_reg && k_reg == 3'd3)
                    state_next = S_SQRT;
                else if (chk_reg && k_reg == 3'd4)
                begin
                    i_next = '0;
                    if (sum_reg < prod_reg)
                        state_next = S_OUTRD;
                    else
                        state_next = S_SETEND;
                end
            end
            S_SQRT:  state_next = S_SQRTW;
            S_SQRTW:
            begin
                if (sq_done)
                    state_next = (phase_reg == PH_MEAS) ? S_SEGWR : S_MUL;
            end
            S_SEGWR:
            begin
                if (i_reg == lastj_reg - 1'b1)
                begin
                    iter_next  = '0;
                    state_next = S_ITCHK;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_RA;
                end
            end
            S_MUL:   state_next = (m_reg == '0) ? S_APPLY : S_DIVGO;
            S_DIVGO: state_next = S_DIVW;
            S_DIVW:
            begin
                if (&dv_done)
                    state_next = S_APPLY;
            end
            S_APPLY:
            begin
                if (phase_reg == PH_FWD)
                begin
                    if (i_reg == '0)
                        state_next = S_SETORG;
                    else
                    begin
                        i_next     = i_reg - 1'b1;
                        state_next = S_RA;
                    end
                end
                else if (i_reg == lastj_reg - 1'b1)
                begin
                    iter_next  = iter_reg + 8'd1;
                    state_next = S_ITCHK;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_RA;
                end
            end
            S_ITCHK:
            begin
                if (iter_reg == max_iter_reg)
                begin
                    i_next     = '0;
                    state_next = S_OUTRD;
                end
                else
                    state_next = S_CHKRD;
            end
            S_CHKRD: state_next = S_CHKD;
            S_CHKD:
            begin
                k_next     = '0;
                chk_next   = 1'b1;
                state_next = S_SQ;
            end
            S_SETEND:
            begin
                i_next     = lastj_reg - 1'b1;
                phase_next = PH_FWD;
                state_next = S_RA;
            end
            S_SETORG:
            begin
                i_next     = '0;
                phase_next = PH_BWD;
                state_next = S_RA;
            end
            S_OUTRD: state_next = S_OUTLD;
            S_OUTLD:
            begin
                outv_next  = 1'b1;
                state_next = S_OUTW;
            end
            S_OUTW:
            begin
                if (!out_stall)
                begin
                    outv_next = 1'b0;
                    if (i_reg == lastj_reg)
                        state_next = S_IDLE;
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = S_OUTRD;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLR;
            phase_reg    <= PH_MEAS;
            i_reg        <= '0;
            lastj_reg    <= '0;
            iter_reg     <= '0;
            k_reg        <= '0;
            chk_reg      <= 1'b0;
            outv_reg     <= 1'b0;
            jcount_reg   <= 5'd6;
            max_iter_reg <= 8'd5;
            thr_reg      <= 32'd655;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            i_reg     <= i_next;
            lastj_reg <= lastj_next;
            iter_reg  <= iter_next;
            k_reg     <= k_next;
            chk_reg   <= chk_next;
            outv_reg  <= outv_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_JOINT_COUNT:     jcount_reg   <= cfg_data[4:0];
                    REG_MAX_ITERATIONS:  max_iter_reg <= cfg_data[7:0];
                    REG_ERROR_THRESHOLD: thr_reg      <= cfg_data;
                    default:             ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (seg_we)
        begin
            seg_mem[i_reg] <= seg_wdata;
        end
        seg_rd_reg <= seg_mem[i_reg];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid && action)
            tgt_reg <= '{x: coord_x, y: coord_y, z: coord_z};
        if (state_reg == S_RB)
        begin
            pa_reg <= jrdata;
            if (phase_reg == PH_MEAS && i_reg == '0)
                org_reg <= jrdata;
        end
        if (state_reg == S_RC)
        begin
            pb_reg  <= jrdata;
            len_reg <= seg_rd_reg;
        end
        if (state_reg == S_DIFF)
        begin
            for (int c = 0; c < 3; c++)
                d_reg[c] <= DIFF_W'(pb_c[c]) - DIFF_W'(pa_c[c]);
        end
        if (state_reg == S_SHIFT)
        begin
            s_reg <= s_calc;
            for (int c = 0; c < 3; c++)
            begin
                logic signed [DIFF_W-1:0] r;
                r = d_reg[c] >>> s_calc;
                rneg_reg[c] <= r[DIFF_W-1];
                rmag_reg[c] <= R_W'(abs_diff(r));
            end
        end
        if (state_reg == S_CHKD)
        begin
            for (int c = 0; c < 3; c++)
                a_reg[c] <= abs_diff(DIFF_W'(rd_c[c]) - DIFF_W'(tgt_c[c]));
        end
        if (state_reg == S_SQ)
        begin
            prod_reg <= mul_op * mul_op;
            if (k_reg == 3'd0)
                sum_reg <= '0;
            else
                sum_reg <= sum_reg + prod_reg;
        end
        if (state_reg == S_SQRTW && sq_done)
            m_reg <= sq_root;
        if (state_reg == S_MUL)
        begin
            for (int c = 0; c < 3; c++)
                num_reg[c] <= NUM_W'(rmag_reg[c] * len_reg);
        end
        if (state_reg == S_OUTLD)
        begin
            opos_reg  <= jrdata;
            oidx_reg  <= i_reg;
            olast_reg <= (i_reg == lastj_reg);
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = outv_reg;
    assign out_index = oidx_reg;
    assign out_x     = opos_reg.x;
    assign out_y     = opos_reg.y;
    assign out_z     = opos_reg.z;
    assign last      = olast_reg;

endmodule
